// ----- rtl/kefuf_pkg.sv -----
// ----------------------------------------------------------------------------
// kefuf_pkg
// shared types and constants of the kruskal edge filter and union-find unit
// ----------------------------------------------------------------------------
package kefuf_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int SIZE_W    = NODE_W + 1;
    localparam int NCNT_W    = 11;
    localparam int WEIGHT_W  = 32;
    localparam int SUM_W     = 42;
    localparam int COUNT_W   = 10;

    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(MAX_NODES - 1);
    localparam logic [SIZE_W-1:0] SIZE_ONE  = SIZE_W'(1);

    typedef struct packed {
        logic                new_graph;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic [WEIGHT_W-1:0] edge_weight;
    } t_in_word;

    typedef struct packed {
        logic               accepted;
        logic [SUM_W-1:0]   total_weight;
        logic [COUNT_W-1:0] edges_taken;
        logic               tree_done;
    } t_out_word;

    // command from the edge sequencer to the forest engine
    typedef struct packed {
        logic              start;
        logic              clear;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_forest_cmd;

    // status back from the forest engine
    typedef struct packed {
        logic idle;
        logic done;
        logic joined;
    } t_forest_resp;

    typedef enum logic [1:0] {
        T_IDLE,
        T_PREP,
        T_FIND,
        T_OUT
    } t_top_state;

    typedef enum logic [2:0] {
        F_IDLE,
        F_CLEAR,
        F_UP,
        F_CMP,
        F_GAP,
        F_SZA,
        F_SZB
    } t_forest_state;

endpackage

// ----- rtl/kefuf_ram.sv -----
// ----------------------------------------------------------------------------
// kefuf_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module kefuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/kefuf_forest.sv -----
// ----------------------------------------------------------------------------
// kefuf_forest
// disjoint-set forest: parent and size memories, clearing sweep, find with
// path compression and union by size
// ----------------------------------------------------------------------------
module kefuf_forest (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  kefuf_pkg::t_forest_cmd i_cmd,
    output kefuf_pkg::t_forest_resp o_resp
);

    kefuf_pkg::t_forest_state r_state, n_state;

    logic [kefuf_pkg::NODE_W-1:0] r_cnt, n_cnt;
    logic [kefuf_pkg::NODE_W-1:0] r_cur, n_cur;
    logic [kefuf_pkg::NODE_W-1:0] r_x, n_x;
    logic [kefuf_pkg::NODE_W-1:0] r_root, n_root;
    logic [kefuf_pkg::NODE_W-1:0] r_ra, n_ra;
    logic [kefuf_pkg::NODE_W-1:0] r_b, n_b;
    logic [kefuf_pkg::SIZE_W-1:0] r_sza, n_sza;
    logic                         r_phase_b, n_phase_b;

    logic                         par_we;
    logic [kefuf_pkg::NODE_W-1:0] par_waddr, par_wdata, par_raddr, par_rdata;
    logic                         size_we;
    logic [kefuf_pkg::NODE_W-1:0] size_waddr, size_raddr;
    logic [kefuf_pkg::SIZE_W-1:0] size_wdata, size_rdata;

    kefuf_ram #(
        .WIDTH (kefuf_pkg::NODE_W),
        .DEPTH (kefuf_pkg::MAX_NODES)
    ) u_parent (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (par_wdata),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    kefuf_ram #(
        .WIDTH (kefuf_pkg::SIZE_W),
        .DEPTH (kefuf_pkg::MAX_NODES)
    ) u_size (
        .i_clk   (i_clk),
        .i_we    (size_we),
        .i_waddr (size_waddr),
        .i_wdata (size_wdata),
        .i_raddr (size_raddr),
        .o_rdata (size_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kefuf_pkg::F_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_cur     <= n_cur;
        r_x       <= n_x;
        r_root    <= n_root;
        r_ra      <= n_ra;
        r_b       <= n_b;
        r_sza     <= n_sza;
        r_phase_b <= n_phase_b;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_cur      = r_cur;
        n_x        = r_x;
        n_root     = r_root;
        n_ra       = r_ra;
        n_b        = r_b;
        n_sza      = r_sza;
        n_phase_b  = r_phase_b;
        par_we     = 1'b0;
        par_waddr  = r_cur;
        par_wdata  = r_root;
        par_raddr  = r_cur;
        size_we    = 1'b0;
        size_waddr = r_ra;
        size_wdata = kefuf_pkg::SIZE_ONE;
        size_raddr = r_ra;
        o_resp     = '0;

        case (r_state)
            kefuf_pkg::F_IDLE: begin
                o_resp.idle = 1'b1;
                if (i_cmd.clear) begin
                    n_cnt   = '0;
                    n_state = kefuf_pkg::F_CLEAR;
                end else if (i_cmd.start) begin
                    n_cur     = i_cmd.node_a;
                    n_x       = i_cmd.node_a;
                    n_b       = i_cmd.node_b;
                    n_phase_b = 1'b0;
                    par_raddr = i_cmd.node_a;
                    n_state   = kefuf_pkg::F_UP;
                end
            end
            kefuf_pkg::F_CLEAR: begin
                // every node its own singleton set
                par_we     = 1'b1;
                par_waddr  = r_cnt;
                par_wdata  = r_cnt;
                size_we    = 1'b1;
                size_waddr = r_cnt;
                size_wdata = kefuf_pkg::SIZE_ONE;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == kefuf_pkg::LAST_NODE) begin
                    n_state = kefuf_pkg::F_IDLE;
                end
            end
            kefuf_pkg::F_UP: begin
                // par_rdata is parent of r_cur
                if (par_rdata == r_cur) begin
                    n_root = r_cur;
                    if (r_x == r_cur) begin
                        n_state = kefuf_pkg::F_GAP;
                    end else begin
                        n_cur     = r_x;
                        par_raddr = r_x;
                        n_state   = kefuf_pkg::F_CMP;
                    end
                end else begin
                    n_cur     = par_rdata;
                    par_raddr = par_rdata;
                end
            end
            kefuf_pkg::F_CMP: begin
                // point r_cur at the root, move on to its old parent
                par_we    = 1'b1;
                par_waddr = r_cur;
                par_wdata = r_root;
                if (par_rdata == r_root) begin
                    n_state = kefuf_pkg::F_GAP;
                end else begin
                    n_cur     = par_rdata;
                    par_raddr = par_rdata;
                end
            end
            kefuf_pkg::F_GAP: begin
                if (!r_phase_b) begin
                    n_ra      = r_root;
                    n_cur     = r_b;
                    n_x       = r_b;
                    n_phase_b = 1'b1;
                    par_raddr = r_b;
                    n_state   = kefuf_pkg::F_UP;
                end else if (r_ra == r_root) begin
                    o_resp.done = 1'b1;
                    n_state     = kefuf_pkg::F_IDLE;
                end else begin
                    size_raddr = r_ra;
                    n_state    = kefuf_pkg::F_SZA;
                end
            end
            kefuf_pkg::F_SZA: begin
                n_sza      = size_rdata;
                size_raddr = r_root;
                n_state    = kefuf_pkg::F_SZB;
            end
            kefuf_pkg::F_SZB: begin
                // larger set keeps its root, ties go to the first endpoint
                size_we    = 1'b1;
                size_wdata = r_sza + size_rdata;
                par_we     = 1'b1;
                if (r_sza < size_rdata) begin
                    size_waddr = r_root;
                    par_waddr  = r_ra;
                    par_wdata  = r_root;
                end else begin
                    size_waddr = r_ra;
                    par_waddr  = r_root;
                    par_wdata  = r_ra;
                end
                o_resp.done   = 1'b1;
                o_resp.joined = 1'b1;
                n_state       = kefuf_pkg::F_IDLE;
            end
            default: begin
                n_state = kefuf_pkg::F_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/kruskal_edge_filter_union_find_unit.sv -----
// ----------------------------------------------------------------------------
// kruskal_edge_filter_union_find_unit
// accept stage of kruskal's spanning tree over a union-find forest in memory
// ----------------------------------------------------------------------------
// steps: a refused word goes straight to the result; otherwise a find walks up
//   from each end and compresses each parent link, and a join of two roots
//   reads both sizes and links them; new_graph first issues a clearing sweep
// flow: one word in flight, the next taken only once the last result is registered
// reset: synchronous, active low; node_count to 1024, then a clearing sweep of
//   both rams that the first word waits out, configuration still taken
module kruskal_edge_filter_union_find_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // edge input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  kefuf_pkg::t_in_word  i_in_word,
    // result output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output kefuf_pkg::t_out_word o_out_word,
    // node_count register
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [kefuf_pkg::NCNT_W-1:0] i_cfg_data
);

    kefuf_pkg::t_top_state r_state, n_state;

    kefuf_pkg::t_in_word           r_item, n_item;
    logic [kefuf_pkg::NCNT_W-1:0]  r_node_count;
    logic [kefuf_pkg::COUNT_W-1:0] r_taken, n_taken;
    logic [kefuf_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic                          r_acc, n_acc;
    logic                          r_out_valid, n_out_valid;
    kefuf_pkg::t_out_word          r_out_word, n_out_word;

    kefuf_pkg::t_forest_cmd        forest_cmd;
    kefuf_pkg::t_forest_resp       forest_resp;

    logic [kefuf_pkg::NCNT_W-1:0]  eff_nodes;
    logic [kefuf_pkg::NCNT_W-1:0]  eff_minus1;
    logic [kefuf_pkg::SUM_W:0]     sum_ext;
    logic                          in_take;
    logic                          out_free;

    kefuf_forest u_forest (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (forest_cmd),
        .o_resp  (forest_resp)
    );

    // effective node count: zero acts as one, clipped to the forest depth
    always_comb begin
        eff_nodes = r_node_count;
        if (r_node_count == '0) begin
            eff_nodes = kefuf_pkg::NCNT_W'(1);
        end else if (r_node_count > kefuf_pkg::NCNT_W'(kefuf_pkg::MAX_NODES)) begin
            eff_nodes = kefuf_pkg::NCNT_W'(kefuf_pkg::MAX_NODES);
        end
        eff_minus1 = eff_nodes - 1'b1;
    end

    // saturating running total
    assign sum_ext = {1'b0, r_sum} + (kefuf_pkg::SUM_W + 1)'(r_item.edge_weight);

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != kefuf_pkg::T_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= kefuf_pkg::T_IDLE;
            r_node_count <= kefuf_pkg::NCNT_W'(1024);
            r_taken      <= '0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_taken     <= n_taken;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
        end
        r_item     <= n_item;
        r_acc      <= n_acc;
        r_out_word <= n_out_word;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_taken     = r_taken;
        n_sum       = r_sum;
        n_acc       = r_acc;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid;
        forest_cmd  = '0;
        forest_cmd.node_a = r_item.node_a;
        forest_cmd.node_b = r_item.node_b;

        // result leaves the output register
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            kefuf_pkg::T_IDLE: begin
                if (in_take) begin
                    n_item  = i_in_word;
                    n_acc   = 1'b0;
                    n_state = kefuf_pkg::T_PREP;
                end
            end
            kefuf_pkg::T_PREP: begin
                // wait out any clearing sweep, including the one after reset
                if (forest_resp.idle) begin
                    if (r_item.new_graph) begin
                        forest_cmd.clear = 1'b1;
                        n_taken          = '0;
                        n_sum            = '0;
                        n_item.new_graph = 1'b0;
                    end else if ({1'b0, r_taken} < eff_minus1
                                 && {1'b0, r_item.node_a} < eff_nodes
                                 && {1'b0, r_item.node_b} < eff_nodes) begin
                        forest_cmd.start = 1'b1;
                        n_state          = kefuf_pkg::T_FIND;
                    end else begin
                        // out of range or tree complete: refused, no change
                        n_state = kefuf_pkg::T_OUT;
                    end
                end
            end
            kefuf_pkg::T_FIND: begin
                if (forest_resp.done) begin
                    if (forest_resp.joined) begin
                        n_acc   = 1'b1;
                        n_taken = r_taken + 1'b1;
                        n_sum   = sum_ext[kefuf_pkg::SUM_W] ? '1
                                                            : sum_ext[kefuf_pkg::SUM_W-1:0];
                    end
                    n_state = kefuf_pkg::T_OUT;
                end
            end
            kefuf_pkg::T_OUT: begin
                if (out_free) begin
                    n_out_word.accepted     = r_acc;
                    n_out_word.total_weight = r_sum;
                    n_out_word.edges_taken  = r_taken;
                    n_out_word.tree_done    = ({1'b0, r_taken} >= eff_minus1);
                    n_out_valid             = 1'b1;
                    n_state                 = kefuf_pkg::T_IDLE;
                end
            end
            default: begin
                n_state = kefuf_pkg::T_IDLE;
            end
        endcase
    end

endmodule
